FILE: hdl/sob_pkg.sv
package sob_pkg;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
    localparam int EFF_LEN_W      = COL_W + 1;

    localparam int PIX_W      = 8;
    localparam int LEN_W      = 11;
    localparam int ROWS_W     = 12;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;

    localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = 11'd638;
    localparam logic [ROWS_W-1:0] ROW_COUNT_RST  = 12'd393;
    localparam int                MIN_DIM        = 3;

    // |grad| <= 1020, so each square fits in 20 bits and the sum in 21
    localparam int ABS_W    = GRAD_W - 1;
    localparam int SQR_W    = 2 * ABS_W;
    localparam int SUM_W    = SQR_W + 1;
    localparam int ROOT_W   = SUM_W + 1;
    localparam int ROOT_TOP = 2 * ((SUM_W - 1) / 2);
    localparam int MAG_MAX  = 255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     valid;
        logic                     fend;
    } grad_t;

endpackage

FILE: hdl/sob_ram.sv
module sob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sob_queue.sv
module sob_queue import sob_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  grad_t push_data,
    output logic  full,
    input  logic  pop,
    output grad_t head,
    output logic  empty
);

    grad_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/sob_front.sv
module sob_front import sob_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  push,
    output grad_t                 push_data,
    input  logic                  queue_full
);

    typedef enum logic {
        F_ACCEPT,
        F_UPDATE
    } fstate_t;

    fstate_t            state_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   win_reg [6];
    logic [COL_W-1:0]   col_reg;
    logic [ROWS_W-1:0]  row_reg;
    logic [LEN_W-1:0]   row_length_reg;
    logic [ROWS_W-1:0]  row_count_reg;

    logic [PIX_W-1:0]     top;
    logic [PIX_W-1:0]     mid;
    logic [EFF_LEN_W-1:0] eff_len;
    logic [ROWS_W-1:0]    eff_rows;
    logic                 last_col;
    logic                 last_row;
    logic                 win_ok;
    logic [PIX_W+1:0]     sum_r, sum_l, sum_t, sum_b;
    logic signed [GRAD_W-1:0] gx, gy;
    logic                 cfg_hit;

    sob_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_LENGTH)) u_mid_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (col_reg),
        .rdata (mid)
    );

    sob_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_LENGTH)) u_top_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (col_reg),
        .wdata (mid),
        .raddr (col_reg),
        .rdata (top)
    );

    assign s_tready  = (state_reg == F_ACCEPT) && !queue_full;
    assign cfg_ready = (state_reg == F_ACCEPT);
    assign cfg_hit   = cfg_valid && cfg_ready
                       && (cfg_index == REG_ROW_LENGTH || cfg_index == REG_ROW_COUNT);
    assign push      = (state_reg == F_UPDATE);

    always_comb begin
        if (int'(row_length_reg) > MAX_ROW_LENGTH) begin
            eff_len = EFF_LEN_W'(MAX_ROW_LENGTH);
        end else if (int'(row_length_reg) < MIN_DIM) begin
            eff_len = EFF_LEN_W'(MIN_DIM);
        end else begin
            eff_len = EFF_LEN_W'(row_length_reg);
        end
        eff_rows = (int'(row_count_reg) < MIN_DIM) ? ROWS_W'(MIN_DIM) : row_count_reg;
    end

    assign last_col = ({1'b0, col_reg} + 1'b1) >= eff_len;
    assign last_row = ({1'b0, row_reg} + 1'b1) >= {1'b0, eff_rows};
    assign win_ok   = (row_reg >= ROWS_W'(2)) && (col_reg >= COL_W'(2));

    // window: [0..2] left column, [3..5] centre column, top to bottom
    assign sum_r = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, pix_reg};
    assign sum_l = {2'b0, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b0, win_reg[2]};
    assign sum_t = {2'b0, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b0, top};
    assign sum_b = {2'b0, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b0, pix_reg};
    assign gx    = signed'({1'b0, sum_r}) - signed'({1'b0, sum_l});
    assign gy    = signed'({1'b0, sum_t}) - signed'({1'b0, sum_b});

    always_comb begin
        push_data.gx    = win_ok ? gx : '0;
        push_data.gy    = win_ok ? gy : '0;
        push_data.valid = win_ok;
        push_data.fend  = last_col && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_ACCEPT;
            col_reg        <= '0;
            row_reg        <= '0;
            row_length_reg <= ROW_LENGTH_RST;
            row_count_reg  <= ROW_COUNT_RST;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                F_ACCEPT: begin
                    if (s_tvalid && s_tready) begin
                        pix_reg   <= s_tdata;
                        state_reg <= F_UPDATE;
                    end
                end
                F_UPDATE: begin
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= top;
                    win_reg[4] <= mid;
                    win_reg[5] <= pix_reg;
                    if (last_col) begin
                        col_reg <= '0;
                        row_reg <= last_row ? '0 : row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                    state_reg <= F_ACCEPT;
                end
                default: begin
                    state_reg <= F_ACCEPT;
                end
            endcase
            // writes are taken only between pixel updates; a write restarts the frame
            if (cfg_hit) begin
                col_reg <= '0;
                row_reg <= '0;
                if (cfg_index == REG_ROW_LENGTH) begin
                    row_length_reg <= cfg_data[LEN_W-1:0];
                end else begin
                    row_count_reg <= cfg_data[ROWS_W-1:0];
                end
            end
        end
    end

endmodule

FILE: hdl/sob_back.sv
module sob_back import sob_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  grad_t             head,
    input  logic              queue_empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [GRAD_W-1:0] out_gx,
    output logic [GRAD_W-1:0] out_gy,
    output logic [MAG_W-1:0]  out_mag,
    output logic              out_valid,
    output logic              out_fend
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_SUM,
        B_ROOT,
        B_OUT
    } bstate_t;

    bstate_t            state_reg;
    grad_t              ent_reg;
    logic [SQR_W-1:0]   sqx_reg, sqy_reg;
    logic [SUM_W-1:0]   n_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [SUM_W-1:0]   bit_reg;
    logic               m_tvalid_reg;
    logic [GRAD_W-1:0]  gx_reg, gy_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               valid_reg, fend_reg;

    logic [ABS_W-1:0]   abs_x, abs_y;
    logic [ROOT_W-1:0]  trial;
    logic               take;
    logic [ROOT_W-3:0]  quarter;
    logic               out_free;

    assign pop      = (state_reg == B_IDLE) && !queue_empty;
    assign abs_x    = ABS_W'(ent_reg.gx[GRAD_W-1] ? -ent_reg.gx : ent_reg.gx);
    assign abs_y    = ABS_W'(ent_reg.gy[GRAD_W-1] ? -ent_reg.gy : ent_reg.gy);
    assign trial    = root_reg + {1'b0, bit_reg};
    assign take     = {1'b0, n_reg} >= trial;
    assign quarter  = root_reg[ROOT_W-1:2];
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign out_gx    = gx_reg;
    assign out_gy    = gy_reg;
    assign out_mag   = mag_reg;
    assign out_valid = valid_reg;
    assign out_fend  = fend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in B_OUT the output register is reloaded instead
            if (m_tvalid_reg && m_tready && state_reg != B_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!queue_empty) begin
                        ent_reg   <= head;
                        state_reg <= B_SQUARE;
                    end
                end
                B_SQUARE: begin
                    sqx_reg   <= abs_x * abs_x;
                    sqy_reg   <= abs_y * abs_y;
                    state_reg <= B_SUM;
                end
                B_SUM: begin
                    n_reg     <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
                    root_reg  <= '0;
                    bit_reg   <= SUM_W'(1) << ROOT_TOP;
                    state_reg <= B_ROOT;
                end
                B_ROOT: begin
                    // one restoring step of the integer square root per cycle
                    if (take) begin
                        n_reg    <= n_reg - trial[SUM_W-1:0];
                        root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == SUM_W'(1)) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        gx_reg       <= ent_reg.gx;
                        gy_reg       <= ent_reg.gy;
                        mag_reg      <= (int'(quarter) > MAG_MAX) ? MAG_W'(MAG_MAX)
                                                                  : MAG_W'(quarter);
                        valid_reg    <= ent_reg.valid;
                        fend_reg     <= ent_reg.fend;
                        state_reg    <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/sobel_3x3_gradient.sv
// The sustained pixel rate is set by the square root unit (one restoring step per cycle,
//   11 steps) plus its load, square, sum and output states; it takes the next queued
//   pixel only once the last result is loaded into the output register.
// The front takes a pixel in two steps (line buffer read, then update) and stalls while
//   the 2-entry queue is full.
// Reset: aresetn synchronous, active low; counters, window, state and config registers return to
//   defaults, line buffers keep old contents (never read into a valid window).
module sobel_3x3_gradient import sob_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [10:0] grad_x, [21:11] grad_y,
                                              // [29:22] magnitude, [31:30] zero
    output logic [0:0]            m_tuser,    // [0] window_valid
    output logic                  m_tlast,    // frame_end
    // register writes: index 0 row_length, index 1 row_count
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              push;
    grad_t             push_data;
    logic              queue_full;
    logic              pop;
    grad_t             head;
    logic              queue_empty;
    logic [GRAD_W-1:0] out_gx, out_gy;
    logic [MAG_W-1:0]  out_mag;
    logic              out_valid, out_fend;

    // front: line buffers, 3x3 window, raster counters, Sobel sums
    sob_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // decouples the front from the multi-cycle magnitude unit
    sob_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    // back: squares, iterative root, saturation, output register
    sob_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_gx      (out_gx),
        .out_gy      (out_gy),
        .out_mag     (out_mag),
        .out_valid   (out_valid),
        .out_fend    (out_fend)
    );

    assign m_tdata = {2'b00, out_mag, out_gy, out_gx};
    assign m_tuser = out_valid;
    assign m_tlast = out_fend;

endmodule

FILE: hdl/sob_checker.sv
module sob_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // border windows carry zero gradients and magnitude
    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("border result not zero");

    // zero gradient gives zero magnitude
    a_flat_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21:0] == 22'd0 |-> m_tdata[29:22] == 8'd0)
        else $error("nonzero magnitude on flat window");

endmodule

bind sobel_3x3_gradient sob_checker u_sob_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
